### sv/apde_pkg.sv
// Shared constants, codes and segment lookup for the price display encoder.
`default_nettype none

package apde_pkg;

    localparam int BIN_W           = 24;
    localparam int DIGITS          = 8;
    localparam int BCD_W           = DIGITS * 4;
    localparam int NUM_STAGES      = 4;
    localparam int STEPS_PER_STAGE = BIN_W / NUM_STAGES;
    localparam int SEG_W           = 7;
    localparam int DOT_W           = 2;

    localparam logic [DOT_W-1:0] DOT_NONE  = 2'd0;
    localparam logic [DOT_W-1:0] DOT_TWO   = 2'd1;
    localparam logic [DOT_W-1:0] DOT_THREE = 2'd2;

    localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;

    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
        logic [SEG_W-1:0] pat;
        unique case (digit)
            4'd0:    pat = 7'h3F;
            4'd1:    pat = 7'h18;
            4'd2:    pat = 7'h6D;
            4'd3:    pat = 7'h7C;
            4'd4:    pat = 7'h5A;
            4'd5:    pat = 7'h76;
            4'd6:    pat = 7'h73;
            4'd7:    pat = 7'h1C;
            4'd8:    pat = 7'h7F;
            4'd9:    pat = 7'h5E;
            default: pat = SEG_BLANK;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

### sv/autorange_price_display_encoder.sv
// Top level of the auto-ranging price display encoder.
`default_nettype none

// Converts a price in hundredths to five seven-segment patterns, a dot lamp
// code and an overflow flag. One transaction is accepted every cycle unless
// the output stalls; each result is registered in four stages of the 24-step
// shift-and-add-3 converter (six steps per stage) and one output stage that
// picks the range and maps digits through the segment table. Backpressure on
// the output stalls the pipeline without losing or repeating a transaction.
module autorange_price_display_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [23:0] i_value_hundredths,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [6:0]  o_seg_pattern_4,
    output logic      [6:0]  o_seg_pattern_3,
    output logic      [6:0]  o_seg_pattern_2,
    output logic      [6:0]  o_seg_pattern_1,
    output logic      [6:0]  o_seg_pattern_0,
    output logic      [1:0]  o_dot_code,
    output logic             o_overflow
);

    localparam int NS = apde_pkg::NUM_STAGES;

    logic                        st_valid [NS+1];
    logic                        st_ready [NS+1];
    logic [apde_pkg::BCD_W-1:0]  st_bcd   [NS+1];
    logic [apde_pkg::BIN_W-1:0]  st_bin   [NS+1];

    assign st_valid[0] = i_valid;
    assign st_bcd[0]   = '0;
    assign st_bin[0]   = i_value_hundredths;
    assign o_ready     = st_ready[0];

    for (genvar g = 0; g < NS; g++) begin : g_stage
        apde_dabble_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[g]),
            .o_ready (st_ready[g]),
            .i_bcd   (st_bcd[g]),
            .i_bin   (st_bin[g]),
            .o_valid (st_valid[g+1]),
            .i_ready (st_ready[g+1]),
            .o_bcd   (st_bcd[g+1]),
            .o_bin   (st_bin[g+1])
        );
    end

    logic [3:0]                  dig [apde_pkg::DIGITS];
    logic                        r_out_vld;
    logic [apde_pkg::SEG_W-1:0]  r_seg [5];
    logic [apde_pkg::SEG_W-1:0]  n_seg [5];
    logic [apde_pkg::DOT_W-1:0]  r_dot;
    logic [apde_pkg::DOT_W-1:0]  n_dot;
    logic                        r_ovf;
    logic                        n_ovf;

    always_comb begin
        for (int d = 0; d < apde_pkg::DIGITS; d++) begin
            dig[d] = st_bcd[NS][d*4 +: 4];
        end
    end

    assign st_ready[NS] = !r_out_vld || i_ready;

    always_comb begin
        n_ovf = 1'b0;
        priority if (dig[7] != 4'd0) begin
            for (int k = 0; k < 5; k++) n_seg[k] = apde_pkg::SEG_BLANK;
            n_dot = apde_pkg::DOT_NONE;
            n_ovf = 1'b1;
        end else if (dig[6] != 4'd0) begin
            for (int k = 0; k < 5; k++) n_seg[k] = apde_pkg::seg_of(dig[k+2]);
            n_dot = apde_pkg::DOT_NONE;
        end else if (dig[5] != 4'd0) begin
            for (int k = 0; k < 5; k++) n_seg[k] = apde_pkg::seg_of(dig[k+1]);
            n_dot = apde_pkg::DOT_THREE;
        end else if (dig[4] != 4'd0) begin
            for (int k = 0; k < 5; k++) n_seg[k] = apde_pkg::seg_of(dig[k]);
            n_dot = apde_pkg::DOT_TWO;
        end else begin
            for (int k = 0; k < 4; k++) n_seg[k] = apde_pkg::seg_of(dig[k]);
            n_seg[4] = apde_pkg::SEG_BLANK;
            n_dot    = apde_pkg::DOT_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (st_ready[NS]) begin
            r_out_vld <= st_valid[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_ready[NS] && st_valid[NS]) begin
            r_seg <= n_seg;
            r_dot <= n_dot;
            r_ovf <= n_ovf;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_seg_pattern_4 = r_seg[4];
    assign o_seg_pattern_3 = r_seg[3];
    assign o_seg_pattern_2 = r_seg[2];
    assign o_seg_pattern_1 = r_seg[1];
    assign o_seg_pattern_0 = r_seg[0];
    assign o_dot_code      = r_dot;
    assign o_overflow      = r_ovf;

`ifndef SYNTHESIS
    a_ovf_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_dot_code == apde_pkg::DOT_NONE
            && o_seg_pattern_4 == apde_pkg::SEG_BLANK
            && o_seg_pattern_0 == apde_pkg::SEG_BLANK))
        else $error("overflow result not blanked");

    a_three_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dot_code == apde_pkg::DOT_THREE)
            |-> (o_seg_pattern_4 != apde_pkg::SEG_BLANK && !o_overflow))
        else $error("dot lamp three with blank leading digit");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_seg_pattern_0)
            && $stable(o_dot_code)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

### sv/apde_dabble_stage.sv
// One registered stage of the shift-and-add-3 binary to BCD converter.
`default_nettype none

module apde_dabble_stage (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [apde_pkg::BCD_W-1:0]  i_bcd,
    input  wire logic [apde_pkg::BIN_W-1:0]  i_bin,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic      [apde_pkg::BCD_W-1:0]  o_bcd,
    output logic      [apde_pkg::BIN_W-1:0]  o_bin
);

    logic                        r_vld;
    logic [apde_pkg::BCD_W-1:0]  r_bcd;
    logic [apde_pkg::BIN_W-1:0]  r_bin;
    logic [apde_pkg::BCD_W-1:0]  n_bcd;
    logic [apde_pkg::BIN_W-1:0]  n_bin;

    always_comb begin
        n_bcd = i_bcd;
        n_bin = i_bin;
        for (int s = 0; s < apde_pkg::STEPS_PER_STAGE; s++) begin
            for (int d = 0; d < apde_pkg::DIGITS; d++) begin
                if (n_bcd[d*4 +: 4] >= 4'd5) begin
                    n_bcd[d*4 +: 4] = n_bcd[d*4 +: 4] + 4'd3;
                end
            end
            {n_bcd, n_bin} = {n_bcd[apde_pkg::BCD_W-2:0], n_bin, 1'b0};
        end
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bcd <= n_bcd;
            r_bin <= n_bin;
        end
    end

    assign o_valid = r_vld;
    assign o_bcd   = r_bcd;
    assign o_bin   = r_bin;

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the auto-ranging price display encoder.
module tb_top;

    typedef enum logic [1:0] {
        PH_STEADY,
        PH_SPARSE_IN,
        PH_SLOW_OUT,
        PH_MIXED
    } t_pace;

    typedef struct packed {
        logic [apde_pkg::BIN_W-1:0] value;
        t_pace                      pace;
        logic                       hold;
        logic                       drain;
    } t_price_item;

    typedef struct packed {
        logic [apde_pkg::SEG_W-1:0] seg4;
        logic [apde_pkg::SEG_W-1:0] seg3;
        logic [apde_pkg::SEG_W-1:0] seg2;
        logic [apde_pkg::SEG_W-1:0] seg1;
        logic [apde_pkg::SEG_W-1:0] seg0;
        logic [apde_pkg::DOT_W-1:0] dot;
        logic                       ovf;
    } t_display;

    localparam int HOLD_CYCLES  = 80;
    localparam int OVF_INT      = 100000;
    localparam int TAIL_CYCLES  = 20;
    localparam int RUN_LIMIT    = 400000;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic [apde_pkg::BIN_W-1:0] i_value_hundredths = '0;
    logic                       i_ready = 1'b0;
    logic                       o_ready;
    logic                       o_valid;
    logic [apde_pkg::SEG_W-1:0] o_seg_pattern_4;
    logic [apde_pkg::SEG_W-1:0] o_seg_pattern_3;
    logic [apde_pkg::SEG_W-1:0] o_seg_pattern_2;
    logic [apde_pkg::SEG_W-1:0] o_seg_pattern_1;
    logic [apde_pkg::SEG_W-1:0] o_seg_pattern_0;
    logic [apde_pkg::DOT_W-1:0] o_dot_code;
    logic                       o_overflow;

    t_price_item price_q[$];
    t_display    display_exp_q[$];

    t_pace tx_pace = PH_STEADY;
    logic  tx_hold = 1'b0;
    int    hold_left = 0;
    int    n_sent = 0;
    int    n_done = 0;
    int    errors = 0;
    int    mismatches = 0;
    int    n_narrow = 0;
    int    n_four = 0;
    int    n_five = 0;
    int    n_ovf = 0;

    autorange_price_display_encoder dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_value_hundredths (i_value_hundredths),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_seg_pattern_4    (o_seg_pattern_4),
        .o_seg_pattern_3    (o_seg_pattern_3),
        .o_seg_pattern_2    (o_seg_pattern_2),
        .o_seg_pattern_1    (o_seg_pattern_1),
        .o_seg_pattern_0    (o_seg_pattern_0),
        .o_dot_code         (o_dot_code),
        .o_overflow         (o_overflow)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [apde_pkg::SEG_W-1:0] digit_lamps(input int unsigned d);
        case (d)
            0:       return 7'h3F;
            1:       return 7'h18;
            2:       return 7'h6D;
            3:       return 7'h7C;
            4:       return 7'h5A;
            5:       return 7'h76;
            6:       return 7'h73;
            7:       return 7'h1C;
            8:       return 7'h7F;
            9:       return 7'h5E;
            default: return apde_pkg::SEG_BLANK;
        endcase
    endfunction

    function automatic t_display predict_display(input logic [apde_pkg::BIN_W-1:0] value);
        int unsigned ip;
        int unsigned fp;
        t_display    r;
        ip = value / 100;
        fp = value % 100;
        r.ovf = 1'b0;
        if (ip < 100) begin
            r.seg4 = apde_pkg::SEG_BLANK;
            r.seg3 = digit_lamps((ip / 10) % 10);
            r.seg2 = digit_lamps(ip % 10);
            r.seg1 = digit_lamps(fp / 10);
            r.seg0 = digit_lamps(fp % 10);
            r.dot  = apde_pkg::DOT_TWO;
        end else if (ip < 1000) begin
            r.seg4 = digit_lamps((ip / 100) % 10);
            r.seg3 = digit_lamps((ip / 10) % 10);
            r.seg2 = digit_lamps(ip % 10);
            r.seg1 = digit_lamps(fp / 10);
            r.seg0 = digit_lamps(fp % 10);
            r.dot  = apde_pkg::DOT_TWO;
        end else if (ip < 10000) begin
            r.seg4 = digit_lamps((ip / 1000) % 10);
            r.seg3 = digit_lamps((ip / 100) % 10);
            r.seg2 = digit_lamps((ip / 10) % 10);
            r.seg1 = digit_lamps(ip % 10);
            r.seg0 = digit_lamps(fp / 10);
            r.dot  = apde_pkg::DOT_THREE;
        end else if (ip < OVF_INT) begin
            r.seg4 = digit_lamps((ip / 10000) % 10);
            r.seg3 = digit_lamps((ip / 1000) % 10);
            r.seg2 = digit_lamps((ip / 100) % 10);
            r.seg1 = digit_lamps((ip / 10) % 10);
            r.seg0 = digit_lamps(ip % 10);
            r.dot  = apde_pkg::DOT_NONE;
        end else begin
            r.seg4 = apde_pkg::SEG_BLANK;
            r.seg3 = apde_pkg::SEG_BLANK;
            r.seg2 = apde_pkg::SEG_BLANK;
            r.seg1 = apde_pkg::SEG_BLANK;
            r.seg0 = apde_pkg::SEG_BLANK;
            r.dot  = apde_pkg::DOT_NONE;
            r.ovf  = 1'b1;
        end
        return r;
    endfunction

    function automatic int idle_pct_in(input t_pace p);
        case (p)
            PH_SPARSE_IN: return 78;
            PH_MIXED:     return 13;
            default:      return 0;
        endcase
    endfunction

    function automatic int stall_pct_out(input t_pace p);
        case (p)
            PH_SLOW_OUT: return 78;
            PH_MIXED:    return 13;
            default:     return 0;
        endcase
    endfunction

    function automatic logic [apde_pkg::BIN_W-1:0] rand_price();
        case ($urandom_range(5, 0))
            0:       return (apde_pkg::BIN_W)'($urandom_range(9999, 0));
            1:       return (apde_pkg::BIN_W)'($urandom_range(99999, 10000));
            2:       return (apde_pkg::BIN_W)'($urandom_range(999999, 100000));
            3:       return (apde_pkg::BIN_W)'($urandom_range(9999999, 1000000));
            4:       return (apde_pkg::BIN_W)'($urandom);
            default: return (apde_pkg::BIN_W)'($urandom_range(16777215, 10000000));
        endcase
    endfunction

    task automatic add_price(input logic [apde_pkg::BIN_W-1:0] v, input t_pace p,
                             input logic hold, input logic drain);
        t_price_item it;
        it.value = v;
        it.pace  = p;
        it.hold  = hold;
        it.drain = drain;
        price_q.push_back(it);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_price_item nxt;
        t_display    exp_r;
        logic        fire;
        logic        launch;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            fire = i_valid && o_ready;
            if (fire) begin
                exp_r = predict_display(i_value_hundredths);
                display_exp_q.push_back(exp_r);
                n_sent <= n_sent + 1;
                if (exp_r.ovf)
                    n_ovf++;
                else if (exp_r.dot == apde_pkg::DOT_TWO)
                    n_narrow++;
                else if (exp_r.dot == apde_pkg::DOT_THREE)
                    n_four++;
                else
                    n_five++;
            end
            if (!i_valid || fire) begin
                launch = 1'b0;
                if (price_q.size() != 0) begin
                    nxt = price_q[0];
                    launch = ($urandom_range(99, 0) >= idle_pct_in(nxt.pace)) &&
                             (!nxt.drain || (!fire && n_sent == n_done));
                end
                if (launch) begin
                    nxt = price_q.pop_front();
                    i_valid            <= 1'b1;
                    i_value_hundredths <= nxt.value;
                    tx_pace            <= nxt.pace;
                    tx_hold            <= nxt.hold;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // long output hold-off
    always @(posedge i_clk) begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (i_valid && o_ready && tx_hold)
            hold_left <= HOLD_CYCLES;
    end

    // monitor
    always @(posedge i_clk) begin
        t_display want;
        t_display got;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                n_done <= n_done + 1;
                got = '{o_seg_pattern_4, o_seg_pattern_3, o_seg_pattern_2,
                        o_seg_pattern_1, o_seg_pattern_0, o_dot_code, o_overflow};
                if (display_exp_q.size() == 0) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: %p", got);
                end else begin
                    want = display_exp_q.pop_front();
                    if (got.seg4 !== want.seg4 || got.seg3 !== want.seg3 ||
                        got.seg2 !== want.seg2 || got.seg1 !== want.seg1 ||
                        got.seg0 !== want.seg0 || got.dot !== want.dot ||
                        got.ovf !== want.ovf) begin
                        errors++;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch #%0d: expected %p, actual %p",
                                     n_done, want, got);
                    end
                end
            end
            if (hold_left != 0)
                i_ready <= 1'b0;
            else
                i_ready <= ($urandom_range(99, 0) >= stall_pct_out(tx_pace));
        end
    end

    initial begin
        logic [apde_pkg::BIN_W-1:0] directed [$];
        t_pace                      p;
        int                         total;
        directed = '{24'd0, 24'd1, 24'd9, 24'd99, 24'd100, 24'd999, 24'd1000,
                     24'd9999, 24'd10000, 24'd99999, 24'd100000, 24'd123456,
                     24'd999999, 24'd1000000, 24'd1234567, 24'd9999999,
                     24'd10000000, 24'd9999900, 24'h0000FF, 24'h555555,
                     24'hAAAAAA, 24'hFFFFFF};
        foreach (directed[k])
            add_price(directed[k], PH_STEADY, 1'b0, 1'b0);
        for (int k = 0; k < 150; k++)
            add_price(rand_price(), PH_STEADY, k == 30, 1'b0);
        for (int ph = 1; ph < 4; ph++) begin
            p = t_pace'(ph);
            for (int k = 0; k < 150; k++)
                add_price(rand_price(), p, 1'b0, k == 0);
        end
        for (int k = 0; k < 30; k++)
            add_price(rand_price(), PH_STEADY, 1'b0, k == 0);
        total = price_q.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (price_q.size() != 0 || i_valid)
            @(posedge i_clk);
        while (n_done < total || display_exp_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d transactions checked under steady, sparse-input, slow-output",
                 n_done);
        $display("and mixed pacing; %0d short, %0d four-digit, %0d five-digit, %0d overflow",
                 n_narrow, n_four, n_five, n_ovf);
        if (errors == 0 && display_exp_q.size() == 0) begin
            $display("PASS autorange_price_display_encoder");
        end else begin
            $display("%0d errors, %0d mismatches", errors, mismatches);
            $display("FAIL autorange_price_display_encoder");
        end
        $finish;
    end

    initial begin
        #RUN_LIMIT;
        $display("timeout with %0d transactions outstanding", display_exp_q.size());
        $display("FAIL autorange_price_display_encoder");
        $finish;
    end

endmodule
